@@ src/dqds_pkg.sv @@
// Shared types and constants for the dual quadrature decoder with speed measure.
`timescale 1ns / 1ps

package dqds_pkg;

  localparam int OUT_WIDTH           = 32;
  localparam int WINDOW_WIDTH        = 24;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = WINDOW_WIDTH'(100);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic capture;
    logic update;
    logic clear;
    logic latch;
  } lane_ctrl_t;

endpackage

@@ src/dual_quadrature_decoder_speed_top.sv @@
// Top level of the two-channel quadrature decoder with windowed speed measure.
`timescale 1ns / 1ps

// Each input word is either a pin sample tick (cmd low) carrying the A and B
// levels of the left and right encoders, or a clear command (cmd high) that
// zeroes both counts and their window baselines. Every accepted word yields
// exactly one result word with both positions, the latched speeds and a flag
// that is set when the speeds were latched by this word.
// A word is taken when in_valid is high and in_stall is low, and a result is
// taken when out_valid is high and out_stall is low. The result appears in the
// cycle after its input word is taken, and one word can be taken every cycle
// unless a result is held under out_stall. Both lanes update on acceptance, so
// the output register is the only stage; in_stall rises only in that case.
// The first tick after reset only records the A levels. The user writes the
// speed window length through cfg_we and cfg_wdata while the block is idle;
// the block does not enforce this. Reset clears all counts, the timer and the
// output valid, and sets the window to 100 ticks.
module dual_quadrature_decoder_speed_top #(
  parameter int COUNT_WIDTH = dqds_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dqds_pkg::WINDOW_WIDTH-1:0]     cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  cmd,
  input  logic                                  left_a,
  input  logic                                  left_b,
  input  logic                                  right_a,
  input  logic                                  right_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] left_position,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] right_position,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] left_velocity,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] right_velocity,
  output logic                                  velocity_fresh
);
  import dqds_pkg::*;

  logic                   ready;
  logic                   accept;
  lane_ctrl_t             ctrl;
  logic [COUNT_WIDTH-1:0] left_pos;
  logic [COUNT_WIDTH-1:0] right_pos;
  logic [COUNT_WIDTH-1:0] left_vel;
  logic [COUNT_WIDTH-1:0] right_vel;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  dqds_timer u_timer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cmd       (cmd),
    .ctrl      (ctrl)
  );

  dqds_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .a        (left_a),
    .b        (left_b),
    .position (left_pos),
    .velocity (left_vel)
  );

  dqds_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .a        (right_a),
    .b        (right_b),
    .position (right_pos),
    .velocity (right_vel)
  );

  dqds_merge #(.COUNT_WIDTH(COUNT_WIDTH)) u_merge (
    .clk            (clk),
    .rst            (rst),
    .load           (accept),
    .fresh          (ctrl.latch),
    .left_pos       (left_pos),
    .right_pos      (right_pos),
    .left_vel       (left_vel),
    .right_vel      (right_vel),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .ready          (ready),
    .left_position  (left_position),
    .right_position (right_position),
    .left_velocity  (left_velocity),
    .right_velocity (right_velocity),
    .velocity_fresh (velocity_fresh)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_CLEAR) |=>
      (left_position == '0) && (right_position == '0) && !velocity_fresh)
    else $error("clear command did not zero positions");

  a_latch_on_tick_only: assert property (@(posedge clk) disable iff (rst)
    ctrl.latch |-> ctrl.update && !ctrl.capture && !ctrl.clear)
    else $error("speed latched outside a counted tick");

endmodule

@@ src/dqds_lane.sv @@
// One encoder lane: 2x quadrature count, window baseline and latched speed.
`timescale 1ns / 1ps

module dqds_lane #(
  parameter int COUNT_WIDTH = dqds_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dqds_pkg::lane_ctrl_t   ctrl,
  input  logic                   a,
  input  logic                   b,
  output logic [COUNT_WIDTH-1:0] position,
  output logic [COUNT_WIDTH-1:0] velocity
);
  import dqds_pkg::*;

  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] total_next;
  logic [COUNT_WIDTH-1:0] baseline;
  logic [COUNT_WIDTH-1:0] baseline_next;
  logic [COUNT_WIDTH-1:0] rate;
  logic [COUNT_WIDTH-1:0] rate_next;
  logic                   prev_a;
  logic                   prev_a_next;
  logic [COUNT_WIDTH-1:0] stepped;

  always_comb begin
    if (a != prev_a) begin
      if (a == b) begin
        stepped = total + COUNT_WIDTH'(1);
      end else begin
        stepped = total - COUNT_WIDTH'(1);
      end
    end else begin
      stepped = total;
    end
  end

  always_comb begin
    total_next    = total;
    baseline_next = baseline;
    rate_next     = rate;
    prev_a_next   = prev_a;
    priority if (ctrl.clear) begin
      total_next    = '0;
      baseline_next = '0;
    end else if (ctrl.capture) begin
      prev_a_next = a;
    end else if (ctrl.update) begin
      prev_a_next = a;
      total_next  = stepped;
      if (ctrl.latch) begin
        rate_next     = stepped - baseline;
        baseline_next = stepped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      baseline <= '0;
      rate     <= '0;
      prev_a   <= 1'b0;
    end else begin
      total    <= total_next;
      baseline <= baseline_next;
      rate     <= rate_next;
      prev_a   <= prev_a_next;
    end
  end

  assign position = total_next;
  assign velocity = rate_next;

endmodule

@@ src/dqds_timer.sv @@
// Window register, priming flag and tick timer that steer both lanes.
`timescale 1ns / 1ps

module dqds_timer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dqds_pkg::WINDOW_WIDTH-1:0]   cfg_wdata,
  input  logic                                accept,
  input  logic                                cmd,
  output dqds_pkg::lane_ctrl_t                ctrl
);
  import dqds_pkg::*;

  logic [WINDOW_WIDTH-1:0] window_ticks;
  logic [WINDOW_WIDTH-1:0] tick_timer;
  logic [WINDOW_WIDTH-1:0] tick_timer_next;
  logic [WINDOW_WIDTH-1:0] timer_inc;
  logic [WINDOW_WIDTH-1:0] win;
  logic                    primed;
  logic                    primed_next;

  assign win       = (window_ticks == '0) ? WINDOW_WIDTH'(1) : window_ticks;
  assign timer_inc = tick_timer + WINDOW_WIDTH'(1);

  always_comb begin
    ctrl.clear   = accept && (cmd == CMD_CLEAR);
    ctrl.capture = accept && (cmd == CMD_TICK) && !primed;
    ctrl.update  = accept && (cmd == CMD_TICK) && primed;
    ctrl.latch   = ctrl.update && ((timer_inc >= win) || (timer_inc == '0));
  end

  always_comb begin
    tick_timer_next = tick_timer;
    primed_next     = primed || ctrl.capture;
    if (ctrl.latch) begin
      tick_timer_next = '0;
    end else if (ctrl.update) begin
      tick_timer_next = timer_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
      tick_timer   <= '0;
      primed       <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_ticks <= cfg_wdata;
      end
      tick_timer <= tick_timer_next;
      primed     <= primed_next;
    end
  end

endmodule

@@ src/dqds_merge.sv @@
// Output stage that joins both lanes into one result word.
`timescale 1ns / 1ps

module dqds_merge #(
  parameter int COUNT_WIDTH = dqds_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic                                  fresh,
  input  logic [COUNT_WIDTH-1:0]                left_pos,
  input  logic [COUNT_WIDTH-1:0]                right_pos,
  input  logic [COUNT_WIDTH-1:0]                left_vel,
  input  logic [COUNT_WIDTH-1:0]                right_vel,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic                                  ready,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] left_position,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] right_position,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] left_velocity,
  output logic signed [dqds_pkg::OUT_WIDTH-1:0] right_velocity,
  output logic                                  velocity_fresh
);
  import dqds_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_position  <= OUT_WIDTH'(signed'(left_pos));
      right_position <= OUT_WIDTH'(signed'(right_pos));
      left_velocity  <= OUT_WIDTH'(signed'(left_vel));
      right_velocity <= OUT_WIDTH'(signed'(right_vel));
      velocity_fresh <= fresh;
    end
  end

endmodule
